// File: rtl/pcst_pkg.sv
package pcst_pkg;

  // Widths fixed by the register map and the item fields.
  localparam int GAP_BITS       = 8;
  localparam int THR_BITS       = 21;
  localparam int TICK_BITS      = 16;
  localparam int MODE_BITS      = 4;
  localparam int CFG_WDATA_BITS = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int GAP_LO_BITS    = 64;
  localparam int GAP_HI_BITS    = 56;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_TABLE_LO = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAP_TABLE_HI = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAIT_TICKS   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_TICKS  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_TICKS  = 3'd5;

  // Phase codes.
  localparam logic [1:0] PH_COUNT = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_DELAY = 2'd2;
  localparam logic [1:0] PH_PULSE = 2'd3;

  // Mode numbers that split the gap table between its two registers.
  localparam logic [MODE_BITS-1:0] MODE_FIRST_LO = 4'd1;
  localparam logic [MODE_BITS-1:0] MODE_FIRST_HI = 4'd9;

  typedef struct packed {
    logic                 edge_a1;
    logic                 edge_a2;
    logic                 edge_b1;
    logic                 edge_b2;
    logic                 sync_edge;
    logic [MODE_BITS-1:0] mode_select;
  } in_t;

  typedef struct packed {
    logic       pulse_level;
    logic [1:0] phase;
    logic       fired;
    logic       sync_timeout;
  } out_t;

  // Threshold lookup result for one word.
  typedef struct packed {
    logic                mode_ok;
    logic [THR_BITS-1:0] thr;
  } thr_t;

endpackage

// File: rtl/pcst_thresh.sv
module pcst_thresh #(
  parameter int MODE_COUNT = 15
) (
  input  logic [pcst_pkg::MODE_BITS-1:0]   mode,
  input  logic [pcst_pkg::GAP_LO_BITS-1:0] gap_lo,
  input  logic [pcst_pkg::GAP_HI_BITS-1:0] gap_hi,
  output pcst_pkg::thr_t                   result
);

  logic [pcst_pkg::GAP_BITS-1:0]   gap;
  logic [2:0]                      lo_sel;
  logic [2:0]                      hi_sel;
  logic [2*pcst_pkg::GAP_BITS-1:0] gap_sq;

  // Pick the gap byte for the mode; modes 1 to 8 live in the low register.
  always_comb begin
    lo_sel = 3'(mode - pcst_pkg::MODE_FIRST_LO);
    hi_sel = 3'(mode - pcst_pkg::MODE_FIRST_HI);
    if (mode == '0) begin
      gap = '0;
    end else if (mode < pcst_pkg::MODE_FIRST_HI) begin
      gap = gap_lo[{lo_sel, 3'b000} +: pcst_pkg::GAP_BITS];
    end else if (hi_sel == 3'd7) begin
      gap = '0;
    end else begin
      gap = gap_hi[{hi_sel, 3'b000} +: pcst_pkg::GAP_BITS];
    end
  end

  // Threshold is gap squared times 25, formed as 16 + 8 + 1 times the square.
  always_comb begin
    gap_sq = 16'(gap) * 16'(gap);
    result.thr = (pcst_pkg::THR_BITS'(gap_sq) << 4) + (pcst_pkg::THR_BITS'(gap_sq) << 3)
                 + pcst_pkg::THR_BITS'(gap_sq);
    result.mode_ok = (mode != '0) && (mode <= pcst_pkg::MODE_BITS'(MODE_COUNT));
  end

endmodule

// File: rtl/pulse_count_sync_trigger.sv
// An accepted word passes through the input register and then the result register.
// One word per cycle unless the result stalls; compare and phase update are combinational.
// An input register and a result register part the two channels: while a result waits,
// the input register takes one more word and the input then stalls until the result goes.
// Reset (rst, synchronous, active high) clears counters, the sync flag, the phase,
// the tick counter and all configuration registers, and empties both registers.
module pulse_count_sync_trigger #(
  parameter int COUNTER_BITS = 16,
  parameter int MODE_COUNT   = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pcst_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pcst_pkg::out_t                       out_data,
  input  logic                                 cfg_write,
  input  logic [pcst_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pcst_pkg::CFG_WDATA_BITS-1:0]  cfg_wdata
);

  localparam int SUM_BITS = COUNTER_BITS + 1;
  localparam int EXT_BITS = (SUM_BITS > 11) ? SUM_BITS : 12;
  localparam int SQ_BITS  = 22;
  localparam int ACC_BITS = SQ_BITS + 1;

  // Configuration registers.
  logic                                 run_enable;
  logic [pcst_pkg::GAP_LO_BITS-1:0]     gap_table_lo;
  logic [pcst_pkg::GAP_HI_BITS-1:0]     gap_table_hi;
  logic [pcst_pkg::TICK_BITS-1:0]       wait_ticks;
  logic [pcst_pkg::TICK_BITS-1:0]       delay_ticks;
  logic [pcst_pkg::TICK_BITS-1:0]       pulse_ticks;

  // Block state.
  logic [COUNTER_BITS-1:0]              count_a1, count_a2, count_b1, count_b2;
  logic [COUNTER_BITS-1:0]              count_a1_next, count_a2_next;
  logic [COUNTER_BITS-1:0]              count_b1_next, count_b2_next;
  logic                                 sync_pending, sync_pending_next;
  logic [1:0]                           phase_reg, phase_next;
  logic [pcst_pkg::TICK_BITS-1:0]       ticks_left, ticks_left_next;

  // Input register.
  logic                                 s1_valid;
  pcst_pkg::in_t                        s1_item;
  pcst_pkg::thr_t                       s1_thr;
  pcst_pkg::thr_t                       thr_in;
  logic                                 advance;

  // Step logic.
  logic [COUNTER_BITS-1:0]              a1_inc, a2_inc, b1_inc, b2_inc;
  logic                                 sync_now;
  logic [SUM_BITS-1:0]                  sum_a, sum_b;
  logic [EXT_BITS-1:0]                  ext_a, ext_b;
  logic [10:0]                          low_a, low_b;
  logic [SQ_BITS-1:0]                   sq_a, sq_b;
  logic [ACC_BITS-1:0]                  sq_sum;
  logic                                 reached;
  logic [pcst_pkg::TICK_BITS-1:0]       ticks_dec;
  logic [1:0]                           pulse_phase;
  logic [pcst_pkg::TICK_BITS-1:0]       pulse_load;
  logic [1:0]                           delay_phase;
  logic [pcst_pkg::TICK_BITS-1:0]       delay_load;
  logic                                 fired, timeout;

  // Threshold for the incoming word, worked out before the word is registered.
  pcst_thresh #(
    .MODE_COUNT (MODE_COUNT)
  ) u_thresh (
    .mode   (in_data.mode_select),
    .gap_lo (gap_table_lo),
    .gap_hi (gap_table_hi),
    .result (thr_in)
  );

  // Handshake: the input register moves on whenever the result register is free.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_data;
      s1_thr  <= thr_in;
    end
  end

  // Counters take this word's edges, and the sync flag its edge, before the phase logic.
  always_comb begin
    a1_inc   = count_a1 + COUNTER_BITS'(s1_item.edge_a1);
    a2_inc   = count_a2 + COUNTER_BITS'(s1_item.edge_a2);
    b1_inc   = count_b1 + COUNTER_BITS'(s1_item.edge_b1);
    b2_inc   = count_b2 + COUNTER_BITS'(s1_item.edge_b2);
    sync_now = sync_pending | s1_item.sync_edge;
    sum_a    = SUM_BITS'(a1_inc) + SUM_BITS'(a2_inc);
    sum_b    = SUM_BITS'(b1_inc) + SUM_BITS'(b2_inc);
  end

  // Exact compare: a sum above 2047 always clears the threshold, else square and add.
  always_comb begin
    ext_a   = EXT_BITS'(sum_a);
    ext_b   = EXT_BITS'(sum_b);
    low_a   = ext_a[10:0];
    low_b   = ext_b[10:0];
    sq_a    = SQ_BITS'(low_a) * SQ_BITS'(low_a);
    sq_b    = SQ_BITS'(low_b) * SQ_BITS'(low_b);
    sq_sum  = ACC_BITS'(sq_a) + ACC_BITS'(sq_b);
    reached = (|ext_a[EXT_BITS-1:11]) || (|ext_b[EXT_BITS-1:11])
              || (sq_sum >= ACC_BITS'(s1_thr.thr));
  end

  // Entry into pulsing and delaying, each skipped when its length is zero.
  always_comb begin
    if (pulse_ticks == '0) begin
      pulse_phase = pcst_pkg::PH_COUNT;
      pulse_load  = '0;
    end else begin
      pulse_phase = pcst_pkg::PH_PULSE;
      pulse_load  = pulse_ticks;
    end
    if (delay_ticks == '0) begin
      delay_phase = pulse_phase;
      delay_load  = pulse_load;
    end else begin
      delay_phase = pcst_pkg::PH_DELAY;
      delay_load  = delay_ticks;
    end
  end

  // Phase sequencer.
  always_comb begin
    count_a1_next     = a1_inc;
    count_a2_next     = a2_inc;
    count_b1_next     = b1_inc;
    count_b2_next     = b2_inc;
    sync_pending_next = sync_now;
    phase_next        = phase_reg;
    ticks_dec         = ticks_left - 1'b1;
    ticks_left_next   = ticks_left;
    fired             = 1'b0;
    timeout           = 1'b0;
    unique case (phase_reg)
      pcst_pkg::PH_COUNT: begin
        if (run_enable && s1_thr.mode_ok && reached) begin
          fired         = 1'b1;
          count_a1_next = '0;
          count_a2_next = '0;
          count_b1_next = '0;
          count_b2_next = '0;
          if (wait_ticks == '0) begin
            phase_next      = delay_phase;
            ticks_left_next = delay_load;
          end else begin
            phase_next      = pcst_pkg::PH_WAIT;
            ticks_left_next = wait_ticks;
          end
        end
      end
      pcst_pkg::PH_WAIT: begin
        if (sync_now) begin
          sync_pending_next = 1'b0;
          phase_next        = delay_phase;
          ticks_left_next   = delay_load;
        end else begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            timeout    = 1'b1;
            phase_next = pcst_pkg::PH_COUNT;
          end
        end
      end
      pcst_pkg::PH_DELAY: begin
        ticks_left_next = ticks_dec;
        if (ticks_dec == '0) begin
          phase_next      = pulse_phase;
          ticks_left_next = pulse_load;
        end
      end
      pcst_pkg::PH_PULSE: begin
        ticks_left_next = ticks_dec;
        if (ticks_dec == '0) begin
          phase_next = pcst_pkg::PH_COUNT;
        end
      end
    endcase
  end

  // State and configuration registers; a run_enable write clears the counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable   <= 1'b0;
      gap_table_lo <= '0;
      gap_table_hi <= '0;
      wait_ticks   <= '0;
      delay_ticks  <= '0;
      pulse_ticks  <= '0;
      count_a1     <= '0;
      count_a2     <= '0;
      count_b1     <= '0;
      count_b2     <= '0;
      sync_pending <= 1'b0;
      phase_reg    <= pcst_pkg::PH_COUNT;
      ticks_left   <= '0;
    end else begin
      if (advance) begin
        count_a1     <= count_a1_next;
        count_a2     <= count_a2_next;
        count_b1     <= count_b1_next;
        count_b2     <= count_b2_next;
        sync_pending <= sync_pending_next;
        phase_reg    <= phase_next;
        ticks_left   <= ticks_left_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          pcst_pkg::REG_RUN_ENABLE: begin
            run_enable <= cfg_wdata[0];
            count_a1   <= '0;
            count_a2   <= '0;
            count_b1   <= '0;
            count_b2   <= '0;
          end
          pcst_pkg::REG_GAP_TABLE_LO: gap_table_lo <= cfg_wdata;
          pcst_pkg::REG_GAP_TABLE_HI: gap_table_hi <= cfg_wdata[pcst_pkg::GAP_HI_BITS-1:0];
          pcst_pkg::REG_WAIT_TICKS:   wait_ticks   <= cfg_wdata[pcst_pkg::TICK_BITS-1:0];
          pcst_pkg::REG_DELAY_TICKS:  delay_ticks  <= cfg_wdata[pcst_pkg::TICK_BITS-1:0];
          pcst_pkg::REG_PULSE_TICKS:  pulse_ticks  <= cfg_wdata[pcst_pkg::TICK_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data.pulse_level  <= (phase_next == pcst_pkg::PH_PULSE);
      out_data.phase        <= phase_next;
      out_data.fired        <= fired;
      out_data.sync_timeout <= timeout;
    end
  end

endmodule

// File: rtl/pcst_checker.sv
module pcst_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input pcst_pkg::out_t out_data
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // The pulse pin is high exactly in the pulsing phase.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pulse_level == (out_data.phase == pcst_pkg::PH_PULSE)))
    else $error("pulse level disagrees with phase");

  // A sync timeout always lands back in counting and never coincides with firing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sync_timeout |->
      (out_data.phase == pcst_pkg::PH_COUNT) && !out_data.fired)
    else $error("sync timeout with wrong phase or firing");

endmodule

bind pulse_count_sync_trigger pcst_checker u_pcst_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
